// ----- rtl/core/op47tt_pkg.sv -----
package op47tt_pkg;

  // parse phases
  localparam logic [1:0] PH_COUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam int NUM_SLOTS = 5;

  localparam logic [16:0] HDR_LAST   = 17'd13;
  localparam logic [16:0] DESC_FIRST = 17'd7;
  localparam logic [16:0] DESC_LAST  = 17'd11;
  localparam logic [16:0] DATA_START = 17'd12;
  localparam logic [5:0]  PKT_LAST   = 6'd44;

  localparam logic [7:0] SDP_ID0 = 8'h43;
  localparam logic [7:0] SDP_ID1 = 8'h02;

  // one extracted teletext byte with its tags
  typedef struct packed {
    logic [7:0]  teletext_byte;
    logic [15:0] line_number;
    logic [2:0]  packet_slot;
    logic [5:0]  byte_index;
    logic        last_in_packet;
  } res_t;

endpackage

// ----- rtl/core/op47tt_parse.sv -----
module op47tt_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [7:0]         byte_i,
  output logic               emit,
  output op47tt_pkg::res_t   res
);
  import op47tt_pkg::*;

  logic [1:0]  phase_r,  phase_nxt;
  logic [16:0] cnt_r,    cnt_nxt;
  logic [15:0] lines_r,  lines_nxt;
  logic [15:0] line_r,   line_nxt;
  logic [16:0] padlen_r, padlen_nxt;
  logic [7:0]  hold_r,   hold_nxt;
  logic [7:0]  desc_r   [NUM_SLOTS];
  logic [7:0]  desc_nxt [NUM_SLOTS];
  logic        sdp_r,    sdp_nxt;
  logic [2:0]  slot_r,   slot_nxt;
  logic [5:0]  poff_r,   poff_nxt;

  logic [16:0] cnt_inc;
  logic [16:0] cnt_sum;
  logic [15:0] lines_dec;
  logic [4:0]  nz;

  // first nonzero slot numbered above the given one, 0 if none
  function automatic logic [2:0] next_slot(input logic [2:0] after, input logic [4:0] mask);
    logic [2:0] found;
    found = 3'd0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mask[s] && (3'(s + 1) > after)) begin
        found = 3'(s + 1);
      end
    end
    return found;
  endfunction

  assign cnt_inc   = cnt_r + 17'd1;
  assign lines_dec = lines_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    lines_nxt  = lines_r;
    line_nxt   = line_r;
    padlen_nxt = padlen_r;
    hold_nxt   = hold_r;
    sdp_nxt    = sdp_r;
    slot_nxt   = slot_r;
    poff_nxt   = poff_r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      desc_nxt[i] = desc_r[i];
    end
    emit = 1'b0;
    res.teletext_byte  = byte_i;
    res.line_number    = line_r;
    res.packet_slot    = slot_r;
    res.byte_index     = poff_r;
    res.last_in_packet = (poff_r == PKT_LAST);
    cnt_sum = {1'b0, hold_r, byte_i} + 17'd3;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      nz[i] = (desc_nxt[i] != 8'd0);
    end

    case (phase_r)
      PH_COUNT: begin
        if (cnt_r == 17'd0) begin
          hold_nxt = byte_i;
          cnt_nxt  = 17'd1;
        end else begin
          lines_nxt = {hold_r, byte_i};
          cnt_nxt   = 17'd0;
          phase_nxt = ({hold_r, byte_i} != 16'd0) ? PH_HEADER : PH_COUNT;
        end
      end
      PH_HEADER: begin
        if (cnt_r == 17'd0 || cnt_r == 17'd4) begin
          hold_nxt = byte_i;
        end else if (cnt_r == 17'd1) begin
          line_nxt = {hold_r, byte_i};
        end else if (cnt_r == 17'd5) begin
          padlen_nxt = {cnt_sum[16:2], 2'b00};
        end
        if (cnt_r >= HDR_LAST) begin
          cnt_nxt  = 17'd0;
          sdp_nxt  = 1'b0;
          slot_nxt = 3'd0;
          poff_nxt = 6'd0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            desc_nxt[i] = 8'd0;
          end
          if (padlen_r == 17'd0) begin
            lines_nxt = lines_dec;
            phase_nxt = (lines_dec != 16'd0) ? PH_HEADER : PH_COUNT;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_PAYLOAD: begin
        if (cnt_r == 17'd0) begin
          hold_nxt = byte_i;
        end else if (cnt_r == 17'd1) begin
          sdp_nxt = (hold_r == SDP_ID0) && (byte_i == SDP_ID1);
        end else if (cnt_r >= DESC_FIRST && cnt_r <= DESC_LAST) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (cnt_r == DESC_FIRST + 17'(i)) begin
              desc_nxt[i] = byte_i;
            end
          end
          if (cnt_r == DESC_LAST) begin
            // the last slot's descriptor arrives with this byte
            slot_nxt = next_slot(3'd0, {(byte_i != 8'd0), nz[3:0]});
            poff_nxt = 6'd0;
          end
        end else if (cnt_r >= DATA_START && sdp_r && slot_r != 3'd0) begin
          emit = 1'b1;
          if (poff_r == PKT_LAST) begin
            slot_nxt = next_slot(slot_r, nz);
            poff_nxt = 6'd0;
          end else begin
            poff_nxt = poff_r + 6'd1;
          end
        end
        cnt_nxt = cnt_inc;
        // line ends at the padded payload end
        if (cnt_inc >= padlen_r) begin
          cnt_nxt   = 17'd0;
          lines_nxt = lines_dec;
          phase_nxt = (lines_dec != 16'd0) ? PH_HEADER : PH_COUNT;
          slot_nxt  = 3'd0;
          poff_nxt  = 6'd0;
        end
      end
      default: begin
        phase_nxt = PH_COUNT;
        cnt_nxt   = 17'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COUNT;
      cnt_r    <= 17'd0;
      lines_r  <= 16'd0;
      line_r   <= 16'd0;
      padlen_r <= 17'd0;
      hold_r   <= 8'd0;
      sdp_r    <= 1'b0;
      slot_r   <= 3'd0;
      poff_r   <= 6'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        desc_r[i] <= 8'd0;
      end
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      lines_r  <= lines_nxt;
      line_r   <= line_nxt;
      padlen_r <= padlen_nxt;
      hold_r   <= hold_nxt;
      sdp_r    <= sdp_nxt;
      slot_r   <= slot_nxt;
      poff_r   <= poff_nxt;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        desc_r[i] <= desc_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/core/op47tt_out_reg.sv -----
module op47tt_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  op47tt_pkg::res_t   res_i,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output op47tt_pkg::res_t   res_o
);
  import op47tt_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  // free now, or emptied by the transfer at this edge
  assign space = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o     = data_r;

endmodule

// ----- rtl/core/anc_op47_teletext_extractor_unit.sv -----
// channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------------------
// in_     | input     | in_valid / in_ready | in_byte
// out_    | output    | out_valid/out_ready | out_teletext_byte, out_line_number,
//         |           |                     | out_packet_slot, out_byte_index,
//         |           |                     | out_last_in_packet
//
// one byte per cycle sustained while the result register has space; a byte's result passes the input
// register, then the parse step into the result register
// the parse state update is the loop that sets this rate
// synchronous active-low reset clears the parse state and both valid flags
// a stalled result register holds the parse step; the input register still takes one
// byte, so in_ready drops only when both stages are full and out_ready is low
module anc_op47_teletext_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_teletext_byte,
  output logic [15:0] out_line_number,
  output logic [2:0]  out_packet_slot,
  output logic [5:0]  out_byte_index,
  output logic        out_last_in_packet
);
  import op47tt_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  logic space;
  logic step_en;
  logic emit;
  res_t res_step;
  res_t res_out;

  // parse advances whenever a byte waits and the result register can take one
  assign step_en  = in_valid_r && space;
  assign in_ready = !in_valid_r || space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  // frame/line/payload parser with the sdp descriptor logic
  op47tt_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_i  (in_byte_r),
    .emit    (emit),
    .res     (res_step)
  );

  // result register, one teletext byte per transfer
  op47tt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && emit),
    .res_i     (res_step),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res_out)
  );

  assign out_teletext_byte  = res_out.teletext_byte;
  assign out_line_number    = res_out.line_number;
  assign out_packet_slot    = res_out.packet_slot;
  assign out_byte_index     = res_out.byte_index;
  assign out_last_in_packet = res_out.last_in_packet;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import op47tt_pkg::*;

  // tracks the frame record parse and holds the teletext bytes still due
  class op47_tracker;
    logic [1:0]  phase;
    logic [16:0] pos;
    logic [15:0] lines_left;
    logic [15:0] line_no;
    logic [16:0] pay_len;
    logic [7:0]  hold;
    logic [7:0]  desc [NUM_SLOTS];
    bit          is_sdp;
    logic [2:0]  slot;
    logic [5:0]  offs;
    res_t        due_bytes [$];
    int          mismatches;

    function new();
      phase      = PH_COUNT;
      pos        = '0;
      lines_left = '0;
      line_no    = '0;
      pay_len    = '0;
      hold       = '0;
      foreach (desc[k]) desc[k] = '0;
      is_sdp     = 1'b0;
      slot       = '0;
      offs       = '0;
      mismatches = 0;
    endfunction

    // next slot above s with a nonzero descriptor, 0 if none
    function logic [2:0] slot_after(logic [2:0] s);
      for (int k = s + 1; k <= NUM_SLOTS; k++) begin
        if (desc[k-1] != 8'd0) return 3'(k);
      end
      return 3'd0;
    endfunction

    function void end_line();
      pos        = '0;
      lines_left = lines_left - 16'd1;
      phase      = (lines_left != 16'd0) ? PH_HEADER : PH_COUNT;
      slot       = '0;
      offs       = '0;
    endfunction

    // one accepted input byte
    function void take_byte(logic [7:0] b);
      res_t r;
      case (phase)
        PH_COUNT: begin
          if (pos == 17'd0) begin
            hold = b;
            pos  = 17'd1;
          end else begin
            lines_left = {hold, b};
            pos        = '0;
            phase      = (lines_left != 16'd0) ? PH_HEADER : PH_COUNT;
          end
        end
        PH_HEADER: begin
          if (pos == 17'd0 || pos == 17'd4) hold = b;
          else if (pos == 17'd1) line_no = {hold, b};
          else if (pos == 17'd5) pay_len = ({1'b0, hold, b} + 17'd3) & ~17'd3;
          if (pos == HDR_LAST) begin
            pos    = '0;
            is_sdp = 1'b0;
            slot   = '0;
            offs   = '0;
            foreach (desc[k]) desc[k] = '0;
            if (pay_len == 17'd0) end_line();
            else phase = PH_PAYLOAD;
          end else begin
            pos = pos + 17'd1;
          end
        end
        default: begin
          if (pos == 17'd0) begin
            hold = b;
          end else if (pos == 17'd1) begin
            is_sdp = (hold == SDP_ID0) && (b == SDP_ID1);
          end else if (pos >= DESC_FIRST && pos <= DESC_LAST) begin
            desc[3'(pos - DESC_FIRST)] = b;
            if (pos == DESC_LAST) begin
              slot = slot_after(3'd0);
              offs = '0;
            end
          end else if (pos >= DATA_START && is_sdp && slot != 3'd0) begin
            r.teletext_byte  = b;
            r.line_number    = line_no;
            r.packet_slot    = slot;
            r.byte_index     = offs;
            r.last_in_packet = (offs == PKT_LAST);
            due_bytes.push_back(r);
            if (offs == PKT_LAST) begin
              slot = slot_after(slot);
              offs = '0;
            end else begin
              offs = offs + 6'd1;
            end
          end
          pos = pos + 17'd1;
          if (pos >= pay_len) end_line();
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // one accepted result against the oldest byte due
    function void match_byte(res_t got);
      res_t want;
      if (due_bytes.size() == 0) begin
        $error("teletext byte 0x%0h on line 0x%0h with none due",
               got.teletext_byte, got.line_number);
        mismatches++;
        return;
      end
      want = due_bytes.pop_front();
      check_field("teletext_byte", want.teletext_byte, got.teletext_byte);
      check_field("line_number", want.line_number, got.line_number);
      check_field("packet_slot", want.packet_slot, got.packet_slot);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("last_in_packet", want.last_in_packet, got.last_in_packet);
    endfunction
  endclass

  // idle cycles with no transfer on either side before the run is called hung
  localparam int IDLE_LIMIT = 2000;
  // random part length in input bytes
  localparam int RANDOM_BYTES = 550;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_teletext_byte;
  logic [15:0] out_line_number;
  logic [2:0]  out_packet_slot;
  logic [5:0]  out_byte_index;
  logic        out_last_in_packet;

  op47_tracker trk = new();
  bit          burst;      // no input gaps while set
  int          n_sent;     // input transfers so far
  int          idle_cnt;

  anc_op47_teletext_extractor_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_teletext_byte  (out_teletext_byte),
    .out_line_number    (out_line_number),
    .out_packet_slot    (out_packet_slot),
    .out_byte_index     (out_byte_index),
    .out_last_in_packet (out_last_in_packet)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // descriptors for slots 1..5, slot 1 in the top byte; about a third left empty
  function automatic logic [39:0] rnd_descs();
    logic [39:0] d;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      d[8*k +: 8] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    return d;
  endfunction

  // one byte transfer; valid stays up across back-to-back transfers
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    trk.take_byte(b);
    n_sent++;
  endtask

  // big-endian 16-bit field
  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // 14-byte line header then at most nbytes of the padded payload; payload
  // bytes 0/1 and the descriptor bytes come from the caller, the rest is random
  task automatic send_line_part(input logic [15:0] line_no, input logic [15:0] smp,
                                input logic [7:0] id0, input logic [7:0] id1,
                                input logic [39:0] descs, input int unsigned nbytes);
    int unsigned padded;
    logic [7:0]  b;
    padded = (int'(smp) + 3) & ~3;
    send_word(line_no);
    send_byte(rnd_byte());   // wrapping
    send_byte(rnd_byte());   // coding
    send_word(smp);
    repeat (8) send_byte(rnd_byte());
    for (int unsigned o = 0; o < padded && o < nbytes; o++) begin
      if (o == 0) b = id0;
      else if (o == 1) b = id1;
      else if (o >= DESC_FIRST && o <= DESC_LAST) b = descs[8*(DESC_LAST - o) +: 8];
      else b = rnd_byte();
      send_byte(b);
    end
  endtask

  // complete line with the whole padded payload
  task automatic send_line(input logic [15:0] line_no, input logic [15:0] smp,
                           input logic [7:0] id0, input logic [7:0] id1,
                           input logic [39:0] descs);
    send_line_part(line_no, smp, id0, id1, descs, 32'hFFFF_FFFF);
  endtask

  // random line: mostly well-formed sdp, some short, near-miss ids and noise
  task automatic random_line();
    int          r;
    int          npk;
    int          len;
    logic [39:0] d;
    logic [7:0]  id0;
    logic [7:0]  id1;
    r   = $urandom_range(0, 9);
    d   = rnd_descs();
    npk = 0;
    for (int k = 0; k < NUM_SLOTS; k++) if (d[8*k +: 8] != 8'd0) npk++;
    id0 = SDP_ID0;
    id1 = SDP_ID1;
    if (r < 6) begin
      // full packets plus trailer, or cut somewhere inside the packets
      if ($urandom_range(0, 3) == 0) len = DATA_START + $urandom_range(0, 45 * npk);
      else len = DATA_START + 45 * npk + $urandom_range(0, 16);
    end else if (r == 6) begin
      // too short for any teletext data
      len = $urandom_range(0, 11);
    end else if (r == 7) begin
      // one bit off the sdp identifier
      if ($urandom_range(0, 1) == 0) id0 = SDP_ID0 ^ (8'd1 << $urandom_range(0, 7));
      else id1 = SDP_ID1 ^ (8'd1 << $urandom_range(0, 7));
      len = $urandom_range(12, 70);
    end else begin
      id0 = rnd_byte();
      id1 = rnd_byte();
      len = $urandom_range(0, 80);
    end
    send_line(16'($urandom_range(0, 65535)), 16'(len), id0, id1, d);
  endtask

  // result side: ready with random stalls, sometimes a long run without any
  initial begin : ready_gen
    int stall;
    out_ready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      stall = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // every result transfer goes to the tracker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      trk.match_byte({out_teletext_byte, out_line_number, out_packet_slot,
                      out_byte_index, out_last_in_packet});
  end

  // hang detection: cycles in a row with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("** anc_op47_teletext_extractor_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int start;
    int nlines;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'd0;
    burst    = 1'b0;
    n_sent   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // empty frame: next two bytes are a line count again
    send_word(16'h0000);
    // no payload, sdp id with short payloads, descriptors complete but no data
    send_word(16'h0004);
    send_line(16'h0000, 16'd0, SDP_ID0, SDP_ID1, 40'hFF_FF_FF_FF_FF);
    send_line(16'hFFFF, 16'd1, SDP_ID0, SDP_ID1, 40'h0);
    send_line(16'h1234, 16'd10, SDP_ID0, SDP_ID1, 40'h01_02_03_04_05);
    send_line(16'h8001, 16'd11, SDP_ID0, SDP_ID1, 40'h01_02_03_04_05);
    // two sparse packets with trailer, then all slots cut short in slot 2
    send_word(16'h0002);
    send_line(16'hFFFF, 16'd109, SDP_ID0, SDP_ID1, 40'h00_FF_00_01_00);
    send_line(16'h0000, 16'd77, SDP_ID0, SDP_ID1, 40'h80_7F_01_FE_55);
    // all-zero descriptors and near-miss identifiers
    send_word(16'h0003);
    send_line(16'h5A5A, 16'd40, SDP_ID0, SDP_ID1, 40'h0);
    send_line(16'hA5A5, 16'd60, SDP_ID0, SDP_ID1 ^ 8'h01, 40'hFF_FF_FF_FF_FF);
    send_line(16'h0101, 16'd60, SDP_ID0 ^ 8'h01, SDP_ID1, 40'hFF_FF_FF_FF_FF);

    // --- random frames ---
    start = n_sent;
    while (n_sent - start < RANDOM_BYTES) begin
      burst  = ($urandom_range(0, 3) == 0);
      nlines = $urandom_range(0, 3);
      send_word(16'(nlines));
      repeat (nlines) random_line();
    end

    // sample count at the top pads to a 65536-byte payload; the stream stops
    // partway through it, two packets and a bit in
    burst = 1'b1;
    send_word(16'h0001);
    send_line_part(16'($urandom_range(0, 65535)), 16'($urandom_range(16'hFFFD, 16'hFFFF)),
                   SDP_ID0, SDP_ID1, 40'h11_22_33_44_55, 32'(DATA_START) + 32'd100);
    burst = 1'b0;
    in_valid <= 1'b0;

    // drain, then catch anything stray
    while (trk.due_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (trk.mismatches == 0) begin
      $display("** anc_op47_teletext_extractor_unit: PASSED **");
    end else begin
      $display("** anc_op47_teletext_extractor_unit: FAILED **");
    end
    $finish;
  end

endmodule
